[hdl/erfd_pkg.sv]
// Shared types, constants and the segment table for the echo range filter display.
package erfd_pkg;

    // Field widths
    localparam int ECHO_W   = 16;
    localparam int CFG_W    = 16;
    localparam int LIMIT_W  = 12;
    localparam int DIST_W   = 12;
    localparam int SEG_W    = 8;
    localparam int DIGITS   = 4;
    localparam int DIGIT_W  = 4;
    localparam int STATE_W  = 28;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 28;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Q0.16 weight complement uses one as 2^16
    localparam logic [MUL_A_W-1:0] ONE_Q16 = 17'h10000;

    // Divide by ten for values below 2^12: q = (x * 52429) >> 19
    localparam logic [MUL_B_W-1:0] DIV10_MUL   = 28'd52429;
    localparam int                 DIV10_SHIFT = 19;
    localparam int                 QUOT_W      = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0]   SCALE_RST  = 16'd3378;
    localparam logic [CFG_W-1:0]   WEIGHT_RST = 16'd655;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 12'd31;

    typedef struct packed {
        logic              op;
        logic [ECHO_W-1:0] echo_us;
    } t_in;

    typedef struct packed {
        logic              running;
        logic [DIST_W-1:0] distance_cm;
        logic              in_range;
        logic [SEG_W-1:0]  seg_thousands;
        logic [SEG_W-1:0]  seg_hundreds;
        logic [SEG_W-1:0]  seg_tens;
        logic [SEG_W-1:0]  seg_units;
        logic [DIGITS-1:0] digit_enables;
    } t_out;

    // Digit 0 is thousands, digit 3 is units
    typedef logic [DIGITS-1:0][DIGIT_W-1:0] t_digits;
    typedef logic [DIGITS-1:0][SEG_W-1:0]   t_segs;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h88;
            4'd1:    s = 8'hBE;
            4'd2:    s = 8'hC4;
            4'd3:    s = 8'hA4;
            4'd4:    s = 8'hB2;
            4'd5:    s = 8'hA1;
            4'd6:    s = 8'h83;
            4'd7:    s = 8'hBC;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'hB0;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

[hdl/erfd_mul.sv]
// Shared registered multiplier used by every multiply step of the sequencer.
module erfd_mul (
    input  logic                         i_clk,
    input  logic [erfd_pkg::MUL_A_W-1:0] i_a,
    input  logic [erfd_pkg::MUL_B_W-1:0] i_b,
    output logic [erfd_pkg::MUL_P_W-1:0] o_p
);

    logic [erfd_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= erfd_pkg::MUL_P_W'(i_a) * erfd_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/erfd_disp.sv]
// Seven-segment encoding with leading-zero blanking for the four-digit readout.
module erfd_disp (
    input  erfd_pkg::t_digits                i_digits,
    input  logic                             i_show,
    output erfd_pkg::t_segs                  o_segs,
    output logic [erfd_pkg::DIGITS-1:0]      o_enables
);

    logic lit;

    // Light every digit from the first nonzero one onward
    always_comb begin
        lit = 1'b0;
        for (int i = 0; i < erfd_pkg::DIGITS; i++) begin
            if (i_digits[i] != '0) begin
                lit = 1'b1;
            end
            o_enables[i] = i_show & lit;
            o_segs[i]    = (i_show & lit) ? erfd_pkg::seg_lookup(i_digits[i]) : '0;
        end
    end

endmodule

[hdl/echo_range_filter_display.sv]
// Top level of the echo range filter display: sequencer, state and config registers.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one word per
// echo measurement or button press; a word is taken when valid is high and
// stall is low. Output channel (o_out_valid / i_out_stall / o_out_data)
// returns exactly one result word per input word, in order.
// Configuration: pulse i_cfg_we with i_cfg_index (0 scale, 1 smoothing
// weight, 2 range limit) and i_cfg_data; index 3 is ignored. Write only
// while the block is idle.
// A button press or an echo while paused goes from accept straight to
// the final step; an echo in run mode first passes through the filter
// update, then three divide-by-ten passes that are skipped when it lands
// out of range. Every multiply step goes through the single shared
// multiplier. The block takes one word at a time and accepts the next
// only once the last has left its final step.
// A finished result sits in an output register; the next word is accepted
// while that result waits. If the receiver stalls and a second result is
// ready, the sequencer holds in its final step until the register frees.
// Reset clears the filter, enters run mode and loads the default config.
module echo_range_filter_display #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  erfd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output erfd_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [erfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [erfd_pkg::CFG_W-1:0]      i_cfg_data
);

    // Q.16 to Q.F conversion shifts
    localparam int LSH  = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
    localparam int RSH  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam int SW   = 2 * erfd_pkg::ECHO_W + LSH;
    // Range compare width covers both the state and the shifted limit
    localparam int LW   = erfd_pkg::LIMIT_W + FRACTION_BITS;
    localparam int CW   = (LW > erfd_pkg::STATE_W) ? LW : erfd_pkg::STATE_W;
    localparam int SUMW = erfd_pkg::MUL_P_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SAMP = 8'b0000_0010,
        S_WS   = 8'b0000_0100,
        S_WF   = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_DIG  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Config registers
    logic [erfd_pkg::CFG_W-1:0]   r_scale;
    logic [erfd_pkg::CFG_W-1:0]   r_weight;
    logic [erfd_pkg::LIMIT_W-1:0] r_limit;

    // Block state
    logic                          r_run;
    logic [erfd_pkg::STATE_W-1:0]  r_filt;

    // Working registers
    logic [erfd_pkg::STATE_W-1:0]  r_sample;
    logic [erfd_pkg::MUL_P_W-1:0]  r_acc;
    logic [erfd_pkg::DIST_W-1:0]   r_dist;
    logic [erfd_pkg::DIST_W-1:0]   r_rem;
    logic [1:0]                    r_cnt;
    logic                          r_show;
    erfd_pkg::t_digits             r_dig;

    // Output register
    logic                          r_out_valid;
    erfd_pkg::t_out                r_out;

    // Shared multiplier operands and product
    logic [erfd_pkg::MUL_A_W-1:0]  mul_a;
    logic [erfd_pkg::MUL_B_W-1:0]  mul_b;
    logic [erfd_pkg::MUL_P_W-1:0]  mul_p;

    logic                          accept;
    logic                          out_free;
    logic [SW-1:0]                 sample_wide;
    logic [erfd_pkg::STATE_W-1:0]  sample_sat;
    logic [SUMW-1:0]               sum;
    logic [erfd_pkg::STATE_W-1:0]  n_filt;
    logic                          in_range;
    logic [erfd_pkg::QUOT_W-1:0]   quot;
    logic [erfd_pkg::DIST_W-1:0]   quot_x10;
    logic [erfd_pkg::DIGIT_W-1:0]  digit;
    erfd_pkg::t_segs               segs;
    logic [erfd_pkg::DIGITS-1:0]   enables;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Route operands to the multiplier for the step being issued
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IDLE: begin
                mul_a = erfd_pkg::MUL_A_W'(i_in_data.echo_us);
                mul_b = erfd_pkg::MUL_B_W'(r_scale);
            end
            S_WS: begin
                mul_a = erfd_pkg::MUL_A_W'(r_weight);
                mul_b = r_sample;
            end
            S_WF: begin
                mul_a = erfd_pkg::ONE_Q16 - erfd_pkg::MUL_A_W'(r_weight);
                mul_b = r_filt;
            end
            S_DIV: begin
                mul_a = erfd_pkg::MUL_A_W'(r_rem);
                mul_b = erfd_pkg::DIV10_MUL;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    erfd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Bring echo * scale to F fraction bits and saturate to the state width
    assign sample_wide = (SW'(mul_p[2*erfd_pkg::ECHO_W-1:0]) << LSH) >> RSH;
    assign sample_sat  = ((sample_wide >> erfd_pkg::STATE_W) != '0) ? '1
                         : erfd_pkg::STATE_W'(sample_wide);

    // Filter update and range check; the weighted sum never exceeds the state width
    assign sum      = r_acc + mul_p;
    assign n_filt   = sum[16 +: erfd_pkg::STATE_W];
    assign in_range = !(CW'(n_filt) > (CW'(r_limit) << FRACTION_BITS));

    // One decimal digit per pass: quotient and remainder by ten
    assign quot     = mul_p[erfd_pkg::DIV10_SHIFT +: erfd_pkg::QUOT_W];
    assign quot_x10 = erfd_pkg::DIST_W'({quot, 3'b000}) + erfd_pkg::DIST_W'({quot, 1'b0});
    assign digit    = erfd_pkg::DIGIT_W'(r_rem - quot_x10);

    erfd_disp u_disp (
        .i_digits  (r_dig),
        .i_show    (r_show),
        .o_segs    (segs),
        .o_enables (enables)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (!i_in_data.op && r_run) ? S_SAMP : S_DONE;
                end
            end
            S_SAMP:  n_state = S_WS;
            S_WS:    n_state = S_WF;
            S_WF:    n_state = S_SUM;
            S_SUM:   n_state = in_range ? S_DIV : S_DONE;
            S_DIV:   n_state = S_DIG;
            S_DIG:   n_state = (r_cnt == 2'd2) ? S_DONE : S_DIV;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b1;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
            r_scale     <= erfd_pkg::SCALE_RST;
            r_weight    <= erfd_pkg::WEIGHT_RST;
            r_limit     <= erfd_pkg::LIMIT_RST;
        end else begin
            r_state <= n_state;

            // Toggle run mode on a button word
            if (accept && i_in_data.op) begin
                r_run <= !r_run;
            end

            // Commit the filtered value
            if (r_state == S_SUM) begin
                r_filt <= n_filt;
            end

            // Load the output register when the final step can hand off
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    erfd_pkg::REG_SCALE:  r_scale  <= i_cfg_data;
                    erfd_pkg::REG_WEIGHT: r_weight <= i_cfg_data;
                    erfd_pkg::REG_LIMIT:  r_limit  <= erfd_pkg::LIMIT_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show <= 1'b0;
            r_cnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_show <= 1'b0;
                    end
                end
                S_SAMP: r_sample <= sample_sat;
                S_WF:   r_acc    <= mul_p;
                S_SUM: begin
                    r_show <= in_range;
                    r_dist <= erfd_pkg::DIST_W'(n_filt >> FRACTION_BITS);
                    r_rem  <= erfd_pkg::DIST_W'(n_filt >> FRACTION_BITS);
                    r_cnt  <= '0;
                end
                S_DIG: begin
                    // Fill units, tens, hundreds; the last quotient is thousands
                    r_dig[2'd3 - r_cnt] <= digit;
                    if (r_cnt == 2'd2) begin
                        r_dig[0] <= erfd_pkg::DIGIT_W'(quot);
                    end
                    r_rem <= erfd_pkg::DIST_W'(quot);
                    r_cnt <= r_cnt + 2'd1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.running       <= r_run;
                        r_out.distance_cm   <= r_show ? r_dist : '0;
                        r_out.in_range      <= r_show;
                        r_out.seg_thousands <= segs[0];
                        r_out.seg_hundreds  <= segs[1];
                        r_out.seg_tens      <= segs[2];
                        r_out.seg_units     <= segs[3];
                        r_out.digit_enables <= enables;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
